@@ rtl/bnrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnrs_pkg
// shared types and constants of the base-n repeated subtraction divider
// ----------------------------------------------------------------------------
package bnrs_pkg;

	localparam int FIELD_W         = 32;
	localparam int DIGIT_W         = 4;
	localparam int FIELD_DIGITS    = FIELD_W / DIGIT_W;
	localparam int DIGIT_COUNT_DEF = 8;

	localparam logic [DIGIT_W-1:0] RADIX_MIN   = 4'd2;
	localparam logic [DIGIT_W-1:0] RADIX_MAX   = 4'd10;
	localparam logic [DIGIT_W-1:0] RADIX_RESET = 4'd10;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DIV0    = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] dividend_digits;
		logic [FIELD_W-1:0] divisor_digits;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] quotient_digits;
		logic [FIELD_W-1:0] remainder_digits;
		logic [1:0]         status;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic check;
		logic shift_in;
		logic advance;
		logic sub;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic early_exit;
		logic borrow;
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/base_n_repeated_subtract_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base_n_repeated_subtract_divider
// radix-n long division by repeated subtraction on packed digit vectors
// ----------------------------------------------------------------------------
// usage
//   input transaction: operands (dividend and divisor, one nibble per digit,
//   least significant digit lowest) taken at a clock edge with start high and
//   busy low. busy stays high until the result has been shown.
//   result transaction: result (quotient, remainder, status) is valid for the
//   single cycle in which done is high; the receiver cannot hold it off.
//   radix register: written by cfg_we/cfg_wdata while idle, by the user's rule,
//   unchecked by the block; below 2 acts as 2, above 10 as 10; reset value is 10.
// timing
//   operands latch at the accept edge; the check state tests digits and zero
//   operands, then for each used digit the shared base-n subtractor is tried until
//   it borrows, each taken subtraction adding one to the quotient digit, then the
//   done state, with done high; the result is taken at the edge after. an invalid
//   digit, zero dividend or zero divisor goes from the check state straight to done.
//   the next transaction is taken in the cycle after done.
// reset
//   arst_n clears the controller to idle and the radix to 10; nothing is
//   pending after reset.
// ----------------------------------------------------------------------------
module base_n_repeated_subtract_divider import bnrs_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	input  wire in_item_t           operands,
	input  wire logic               cfg_we,
	input  wire logic [DIGIT_W-1:0] cfg_wdata,
	output      logic               done,
	output      out_item_t          result
);

	// command and status between controller and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: latch, check, per-digit subtract loop, done
	bnrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// operand, remainder and quotient registers with the base-n subtractor
	bnrs_dp #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.operands  (operands),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

`default_nettype wire

@@ rtl/bnrs_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnrs_dp
// datapath: radix register, operand and remainder registers, base-n subtractor
// ----------------------------------------------------------------------------
module bnrs_dp import bnrs_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [DIGIT_W-1:0]  cfg_wdata,
	input  wire in_item_t            operands,
	input  wire dp_cmd_t             cmd,
	output      dp_stat_t            stat,
	output      out_item_t           result
);

	localparam int NUM_DIGITS = (DIGIT_COUNT < FIELD_DIGITS) ? DIGIT_COUNT : FIELD_DIGITS;
	localparam int DW         = NUM_DIGITS * DIGIT_W;
	localparam int RW         = (NUM_DIGITS + 1) * DIGIT_W;
	localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

	logic [DIGIT_W-1:0] radix_q;
	logic [DIGIT_W-1:0] radix_eff;
	logic [DIGIT_W-1:0] radix_eff_q;
	logic [DW-1:0]      a_q;
	logic [DW-1:0]      b_q;
	logic [RW-1:0]      rem_q;
	logic [DW-1:0]      quot_q;
	logic [DIGIT_W-1:0] qd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         status_q;

	logic [RW-1:0]         diff;
	logic                  borrow_out;
	logic                  bad_digit;
	logic [RW+DIGIT_W-1:0] rem_shift;
	logic [DW+DIGIT_W-1:0] quot_shift;
	logic [1:0]            status_next;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (radix_q inside {[RADIX_MIN:RADIX_MAX]}) begin
			radix_eff = radix_q;
		end else if (radix_q < RADIX_MIN) begin
			radix_eff = RADIX_MIN;
		end else begin
			radix_eff = RADIX_MAX;
		end
	end

	// digit range check over the latched operands
	always_comb begin
		bad_digit = 1'b0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (a_q[i*DIGIT_W +: DIGIT_W] >= radix_eff_q ||
			    b_q[i*DIGIT_W +: DIGIT_W] >= radix_eff_q) begin
				bad_digit = 1'b1;
			end
		end
	end

	always_comb begin
		if (bad_digit) begin
			status_next = STATUS_INVALID;
		end else if (a_q == '0) begin
			status_next = STATUS_OK;
		end else if (b_q == '0) begin
			status_next = STATUS_DIV0;
		end else begin
			status_next = STATUS_OK;
		end
	end

	// base-n ripple-borrow subtractor: partial remainder minus divisor
	always_comb begin
		logic [RW-1:0]      b_ext;
		logic [DIGIT_W:0]   d;
		logic               bw;
		b_ext = RW'(b_q);
		bw    = 1'b0;
		diff  = '0;
		for (int i = 0; i <= NUM_DIGITS; i++) begin
			d = {1'b0, rem_q[i*DIGIT_W +: DIGIT_W]} - {1'b0, b_ext[i*DIGIT_W +: DIGIT_W]}
			    - {{DIGIT_W{1'b0}}, bw};
			if (d[DIGIT_W]) begin
				d  = d + {1'b0, radix_eff_q};
				bw = 1'b1;
			end else begin
				bw = 1'b0;
			end
			diff[i*DIGIT_W +: DIGIT_W] = d[DIGIT_W-1:0];
		end
		borrow_out = bw;
	end

	assign rem_shift  = {rem_q, a_q[DW-1 -: DIGIT_W]};
	assign quot_shift = {quot_q, qd_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q         <= operands.dividend_digits[DW-1:0];
			b_q         <= operands.divisor_digits[DW-1:0];
			radix_eff_q <= radix_eff;
			rem_q       <= '0;
			quot_q      <= '0;
			qd_q        <= '0;
			cnt_q       <= CNT_W'(NUM_DIGITS);
		end else begin
			if (cmd.check) begin
				status_q <= status_next;
			end
			if (cmd.sub) begin
				rem_q <= diff;
				qd_q  <= qd_q + 4'd1;
			end
			if (cmd.advance) begin
				quot_q <= quot_shift[DW-1:0];
				qd_q   <= '0;
			end
			if (cmd.shift_in) begin
				rem_q <= rem_shift[RW-1:0];
				a_q   <= a_q << DIGIT_W;
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign stat.early_exit = bad_digit || (a_q == '0) || (b_q == '0);
	assign stat.borrow     = borrow_out;
	assign stat.last       = (cnt_q == '0);

	assign result.quotient_digits  = FIELD_W'(quot_q);
	assign result.remainder_digits = FIELD_W'(rem_q[DW-1:0]);
	assign result.status           = status_q;

`ifndef NO_ASSERTIONS
	// a quotient digit never reaches the radix
	a_qdigit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sub |-> (qd_q < radix_eff_q - 4'd1))
		else $error("quotient digit overflow");

	// the top digit of the partial remainder is zero before a new digit is shifted in
	a_rem_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_in |-> (rem_q[RW-1 -: DIGIT_W] == '0))
		else $error("remainder top digit lost on shift");

	// never subtract when the trial subtraction would go negative
	a_sub_no_borrow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sub |-> !borrow_out)
		else $error("subtraction taken with borrow");
`endif

endmodule

`default_nettype wire

@@ rtl/bnrs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bnrs_ctrl
// controller state machine sequencing the digit-by-digit subtraction
// ----------------------------------------------------------------------------
module bnrs_ctrl import bnrs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output      dp_cmd_t  cmd,
	output      logic     busy,
	output      logic     done
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_TRY   = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load   = 1'b1;
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.early_exit) begin
					state_next = S_DONE;
				end else begin
					cmd.shift_in = 1'b1;
					state_next   = S_TRY;
				end
			end
			S_TRY: begin
				if (!stat.borrow) begin
					cmd.sub = 1'b1;
				end else if (stat.last) begin
					cmd.advance = 1'b1;
					state_next  = S_DONE;
				end else begin
					cmd.advance  = 1'b1;
					cmd.shift_in = 1'b1;
				end
			end
			S_DONE: begin
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

`ifndef NO_ASSERTIONS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not raise busy");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sub |-> (!cmd.advance && !cmd.shift_in && !cmd.load))
		else $error("subtract issued with another remainder update");
`endif

endmodule

`default_nettype wire
